>>> hdl/cfp_pkg.sv
// Package: shared types and codes of the command frame parser.
package cfp_pkg;

  typedef enum logic [2:0] {
    ST_INCOMPLETE = 3'd0,
    ST_SUCCESS    = 3'd1,
    ST_HEADER     = 3'd2,
    ST_CMD        = 3'd3,
    ST_LENGTH     = 3'd4,
    ST_CSUM       = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LENLO = 3'd3,
    PH_LENHI = 3'd4,
    PH_DATA  = 3'd5,
    PH_CSUM  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_CMD_LOWER     = 2'd2,
    REG_CMD_UPPER     = 2'd3
  } reg_idx_e;

  localparam int unsigned PaddrW = 4;

  localparam logic [7:0] HeaderFirstRst  = 8'h55;
  localparam logic [7:0] HeaderSecondRst = 8'hAA;
  localparam logic [7:0] CmdLowerRst     = 8'h00;
  localparam logic [7:0] CmdUpperRst     = 8'hFF;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] cmd_lower_exclusive;
    logic [7:0] cmd_upper_exclusive;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  frame_command;
    logic [9:0]  frame_length;
  } result_t;

endpackage

>>> hdl/cfp_if.sv
// Interfaces: received byte channel and parse result channel.
interface cfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [9:0] payload_index;
  logic [7:0] frame_command;
  logic [9:0] frame_length;

  modport source (output valid, output status, output payload_valid, output payload_byte,
                  output payload_index, output frame_command, output frame_length,
                  input ready);
  modport sink   (input valid, input status, input payload_valid, input payload_byte,
                  input payload_index, input frame_command, input frame_length,
                  output ready);
endinterface

>>> hdl/command_frame_parser.sv
// Top level: byte-serial command frame parser with checksum and APB configuration.
//
// rx_i carries received bytes (valid/ready); every byte accepted yields exactly one
// beat on res_o: a status code, the byte itself with its index when it was payload,
// and the command and length of the frame when its checksum checked out.
// Frame: header_first, header_second, command, length low, length high, payload,
// checksum (inverted 8-bit sum of command, length bytes and payload).
// Flow: a byte lands in the input register, then one pass through the frame
// state machine fills the result register, which drives the beat on res_o.
// Throughput is one byte per cycle while res_o is not held off; the frame state
// machine is the only logic between the two registers.
// Stalls: while res_o is held off, the input register still takes one more beat,
// then rx_i.ready drops until the result register drains.
// Reset: header values 0x55/0xAA, command bounds 0/255, parser waits for a first
// header byte, both stages empty. APB: registers at byte offsets 0, 4, 8, 12, to be
// written by the user only while the block is idle; the block does not enforce it.
module command_frame_parser
  import cfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cfp_byte_if.sink          rx_i,
  cfp_result_if.source      res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    in_ready;

  cfp_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cfp_parser_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (rx_i.valid),
    .in_byte_i   (rx_i.rx_byte),
    .in_ready_o  (in_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_o.ready)
  );

  assign rx_i.ready          = in_ready;
  // result beat fields
  assign res_o.valid         = res_valid;
  assign res_o.status        = res.status;
  assign res_o.payload_valid = res.payload_valid;
  assign res_o.payload_byte  = res.payload_byte;
  assign res_o.payload_index = res.payload_index;
  assign res_o.frame_command = res.frame_command;
  assign res_o.frame_length  = res.frame_length;

endmodule

>>> hdl/cfp_cfg_regs.sv
// APB register bank: header values and command bounds.
module cfp_cfg_regs
  import cfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_HEADER_FIRST:  cfg_d.header_first        = pwdata[7:0];
        REG_HEADER_SECOND: cfg_d.header_second       = pwdata[7:0];
        REG_CMD_LOWER:     cfg_d.cmd_lower_exclusive = pwdata[7:0];
        REG_CMD_UPPER:     cfg_d.cmd_upper_exclusive = pwdata[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEADER_FIRST:  prdata = {24'h0, cfg_q.header_first};
      REG_HEADER_SECOND: prdata = {24'h0, cfg_q.header_second};
      REG_CMD_LOWER:     prdata = {24'h0, cfg_q.cmd_lower_exclusive};
      REG_CMD_UPPER:     prdata = {24'h0, cfg_q.cmd_upper_exclusive};
      default:           prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first        <= HeaderFirstRst;
      cfg_q.header_second       <= HeaderSecondRst;
      cfg_q.cmd_lower_exclusive <= CmdLowerRst;
      cfg_q.cmd_upper_exclusive <= CmdUpperRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/cfp_parser_core.sv
// Parser core: input register, frame state machine with running sum, result register.
module cfp_parser_core
  import cfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  output logic       res_valid_o,
  output result_t    res_o,
  input  logic       res_ready_i
);

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD);

  // input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  // result stage
  logic       res_valid_q;
  result_t    res_q, res_d;
  // frame state
  phase_e            phase_q, phase_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [15:0]       len_q, len_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [7:0]        sum_q, sum_d;

  logic        advance;
  logic        fire;
  logic [15:0] len_new;
  logic [15:0] cnt_ext;
  logic [15:0] idx_ext;
  logic [7:0]  b;

  assign advance     = !res_valid_q || res_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign fire        = in_valid_q && advance;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign b       = in_byte_q;
  assign len_new = {b, len_q[7:0]};
  // count after this payload byte
  assign cnt_ext = 16'(cnt_q) + 16'd1;
  assign idx_ext = 16'(cnt_q);

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    res_d   = '0;
    res_d.status = ST_INCOMPLETE;
    case (phase_q)
      PH_HEAD1: begin
        if (b == cfg_i.header_first) phase_d = PH_HEAD2;
      end
      PH_HEAD2: begin
        if (b == cfg_i.header_second) begin
          phase_d = PH_CMD;
        end else begin
          phase_d      = PH_HEAD1;
          res_d.status = ST_HEADER;
        end
      end
      PH_CMD: begin
        if (b > cfg_i.cmd_lower_exclusive && b < cfg_i.cmd_upper_exclusive) begin
          cmd_d   = b;
          sum_d   = b;
          phase_d = PH_LENLO;
        end else begin
          phase_d      = PH_HEAD1;
          res_d.status = ST_CMD;
        end
      end
      PH_LENLO: begin
        len_d   = {8'h00, b};
        sum_d   = sum_q + b;
        phase_d = PH_LENHI;
      end
      PH_LENHI: begin
        cnt_d = '0;
        len_d = len_new;
        sum_d = sum_q + b;
        if (len_new == 16'h0000) begin
          phase_d = PH_CSUM;
        end else if ({1'b0, len_new} < 17'(MAX_PAYLOAD)) begin
          phase_d = PH_DATA;
        end else begin
          phase_d      = PH_HEAD1;
          res_d.status = ST_LENGTH;
        end
      end
      PH_DATA: begin
        res_d.payload_valid = 1'b1;
        res_d.payload_byte  = b;
        res_d.payload_index = idx_ext[9:0];
        sum_d = sum_q + b;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_ext >= len_q) phase_d = PH_CSUM;
      end
      PH_CSUM: begin
        if (~sum_q == b) begin
          res_d.status        = ST_SUCCESS;
          res_d.frame_command = cmd_q;
          res_d.frame_length  = len_q[9:0];
        end else begin
          res_d.status = ST_CSUM;
        end
        phase_d = PH_HEAD1;
      end
      default: phase_d = PH_HEAD1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      phase_q     <= PH_HEAD1;
      cmd_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) res_valid_q <= in_valid_q;
      if (fire) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_byte_q <= in_byte_i;
    if (fire) res_q <= res_d;
  end

endmodule

>>> bench/command_frame_parser_tb.sv
`timescale 1ns / 1ps
// Testbench: command frame parser, frames and noise checked against a cycle-free parse model.
module command_frame_parser_tb;
  import cfp_pkg::*;

  localparam int unsigned FrameLenLimit = 1024;  // payload length must stay below this
  localparam int unsigned HalfPeriod    = 6;
  localparam int unsigned SettleCycles  = 6;     // pipeline is two deep, leave some slack
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned PhaseBudget   = 200;   // random beats per random-traffic phase

  logic clk_i = 1'b0;
  logic rst_ni;

  // APB side
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  cfp_byte_if   byte_if ();
  cfp_result_if res_if ();

  command_frame_parser #(
    .MAX_PAYLOAD(FrameLenLimit)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (byte_if.sink),
    .res_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parse model: our own copy of the registers and the frame state.
  // ---------------------------------------------------------------------------
  cfg_t        parser_cfg;
  phase_e      frame_phase_q;
  logic [7:0]  frame_cmd_q;
  logic [15:0] frame_len_q;
  logic [15:0] payload_count_q;
  logic [7:0]  frame_sum_q;

  // One outcome per accepted byte, oldest first.
  result_t parse_results_q[$];

  int unsigned beats_sent;
  int unsigned fault_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_off_left;

  // Advance the frame state by one byte and return what the block should report.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.status = ST_INCOMPLETE;
    case (frame_phase_q)
      PH_HEAD1: begin
        // anything other than the first header byte is dropped quietly
        if (b == parser_cfg.header_first) frame_phase_q = PH_HEAD2;
      end
      PH_HEAD2: begin
        // a wrong second byte is flagged and is not re-examined as a first header
        if (b == parser_cfg.header_second) begin
          frame_phase_q = PH_CMD;
        end else begin
          frame_phase_q = PH_HEAD1;
          r.status      = ST_HEADER;
        end
      end
      PH_CMD: begin
        if (b > parser_cfg.cmd_lower_exclusive && b < parser_cfg.cmd_upper_exclusive) begin
          frame_cmd_q   = b;
          frame_sum_q   = b;
          frame_phase_q = PH_LENLO;
        end else begin
          frame_phase_q = PH_HEAD1;
          r.status      = ST_CMD;
        end
      end
      PH_LENLO: begin
        frame_len_q   = {8'h00, b};
        frame_sum_q   = frame_sum_q + b;
        frame_phase_q = PH_LENHI;
      end
      PH_LENHI: begin
        payload_count_q = '0;
        frame_len_q     = {b, frame_len_q[7:0]};
        frame_sum_q     = frame_sum_q + b;
        if (frame_len_q == 16'd0) begin
          frame_phase_q = PH_CSUM;  // empty payload: checksum follows at once
        end else if (frame_len_q < FrameLenLimit) begin
          frame_phase_q = PH_DATA;
        end else begin
          frame_phase_q = PH_HEAD1;
          r.status      = ST_LENGTH;
        end
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = payload_count_q[9:0];
        frame_sum_q     = frame_sum_q + b;
        payload_count_q = payload_count_q + 16'd1;
        if (payload_count_q >= frame_len_q) frame_phase_q = PH_CSUM;
      end
      PH_CSUM: begin
        if (8'(~frame_sum_q) == b) begin
          r.status        = ST_SUCCESS;
          r.frame_command = frame_cmd_q;
          r.frame_length  = frame_len_q[9:0];
        end else begin
          r.status = ST_CSUM;
        end
        frame_phase_q = PH_HEAD1;
      end
      default: frame_phase_q = PH_HEAD1;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge; callers start there too.
  // ---------------------------------------------------------------------------

  // Offer one byte, with random idle cycles first. valid stays up after the beat,
  // so back-to-back bytes never see it dropped and raised in one step.
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    parse_results_q.push_back(parse_byte(b));
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every outcome has been seen, plus the SettleCycles margin.
  task automatic wait_parse_drained();
    byte_if.valid <= 1'b0;
    while (parse_results_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // APB write: setup then access; the register takes it at the access edge.
  task automatic write_reg(input reg_idx_e idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), value};  // upper bits must be ignored
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEADER_FIRST:  parser_cfg.header_first        = value;
      REG_HEADER_SECOND: parser_cfg.header_second       = value;
      REG_CMD_LOWER:     parser_cfg.cmd_lower_exclusive = value;
      REG_CMD_UPPER:     parser_cfg.cmd_upper_exclusive = value;
      default: ;
    endcase
  endtask

  task automatic set_parser_cfg(input logic [7:0] h1, input logic [7:0] h2,
                                input logic [7:0] lo, input logic [7:0] hi);
    wait_parse_drained();
    write_reg(REG_HEADER_FIRST, h1);
    write_reg(REG_HEADER_SECOND, h2);
    write_reg(REG_CMD_LOWER, lo);
    write_reg(REG_CMD_UPPER, hi);
  endtask

  // Send a frame as far as the parser will take it. Random payload; the checksum is
  // right unless csum_ok is clear, in which case one bit of it is flipped.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input bit csum_ok);
    logic [7:0] sum;
    logic [7:0] d;
    sum = cmd + len[7:0] + len[15:8];
    send_rx_byte(parser_cfg.header_first);
    send_rx_byte(parser_cfg.header_second);
    send_rx_byte(cmd);
    if (!(cmd > parser_cfg.cmd_lower_exclusive && cmd < parser_cfg.cmd_upper_exclusive)) return;
    send_rx_byte(len[7:0]);
    send_rx_byte(len[15:8]);
    if (len >= FrameLenLimit) return;
    for (int i = 0; i < len; i++) begin
      d   = 8'($urandom);
      sum = sum + d;
      send_rx_byte(d);
    end
    send_rx_byte(csum_ok ? ~sum : ~sum ^ (8'h01 << $urandom_range(7)));
  endtask

  // Command inside the bounds when asked and possible, else one at or past a bound.
  function automatic logic [7:0] pick_command(input bit legal);
    int lo;
    int hi;
    lo = parser_cfg.cmd_lower_exclusive;
    hi = parser_cfg.cmd_upper_exclusive;
    if (legal && lo + 1 < hi) return 8'($urandom_range(hi - 1, lo + 1));
    if ($urandom_range(1)) return 8'($urandom_range(lo, 0));
    return 8'($urandom_range(255, hi));
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 16'd0;
    if (r < 75) return 16'($urandom_range(8, 1));
    return 16'($urandom_range(48, 9));
  endfunction

  // Mostly well-formed frames with random content; the rest broken frames and noise.
  task automatic run_frame_mix(input int unsigned budget);
    int unsigned start;
    int unsigned r;
    logic [7:0]  b;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 65) begin
        send_frame(pick_command(1'b1), pick_length(), 1'b1);
      end else if (r < 72) begin
        send_frame(pick_command(1'b1), pick_length(), 1'b0);
      end else if (r < 77) begin
        send_frame(pick_command(1'b0), pick_length(), 1'b1);
      end else if (r < 82) begin
        send_frame(pick_command(1'b1), 16'($urandom_range(65535, FrameLenLimit)), 1'b1);
      end else if (r < 87) begin
        b = 8'($urandom);
        if (b == parser_cfg.header_second) b = b ^ 8'h01;
        send_rx_byte(parser_cfg.header_first);
        send_rx_byte(b);
      end else if (r < 92) begin
        // frame cut short; whatever follows gets parsed as its tail
        send_rx_byte(parser_cfg.header_first);
        send_rx_byte(parser_cfg.header_second);
        repeat ($urandom_range(4)) send_rx_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) send_rx_byte(8'($urandom));
      end
    end
    wait_parse_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stray bytes before a header, a wrong second byte, and a repeated first byte.
  task automatic test_header_mismatch();
    send_rx_byte(8'h00);
    send_rx_byte(HeaderFirstRst);
    send_rx_byte(8'hFF);
    send_rx_byte(HeaderFirstRst);
    send_rx_byte(HeaderFirstRst);  // reported, not taken as a fresh first header
    wait_parse_drained();
  endtask

  // Both bound values themselves are rejected.
  task automatic test_command_bounds();
    send_frame(8'h00, 16'd0, 1'b1);
    send_frame(8'hFF, 16'd0, 1'b1);
    wait_parse_drained();
  endtask

  task automatic test_checksum_paths();
    send_frame(8'hFE, 16'd0, 1'b1);  // empty payload straight to checksum
    send_frame(8'h01, 16'd1, 1'b0);
    wait_parse_drained();
  endtask

  task automatic test_length_limit();
    send_frame(8'h80, 16'(FrameLenLimit), 1'b1);
    wait_parse_drained();
  endtask

  // A long frame while the result side is held off: the input must stall. The
  // sender then waits for every outcome before it offers the next frame.
  task automatic test_backpressure();
    hold_off_left = 300;
    send_frame(8'h42, 16'd64, 1'b1);
    byte_if.valid <= 1'b0;
    while (parse_results_q.size() != 0) @(negedge clk_i);
    send_frame(8'h43, 16'd2, 1'b1);
    wait_parse_drained();
  endtask

  // Lower bound above upper bound: no command can pass.
  task automatic test_empty_command_range();
    set_parser_cfg(HeaderFirstRst, HeaderSecondRst, 8'hFF, 8'h00);
    send_frame(8'h80, 16'd0, 1'b1);
    send_frame(8'h00, 16'd0, 1'b1);
    wait_parse_drained();
  endtask

  task automatic test_random_no_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_frame_mix(PhaseBudget);
  endtask

  task automatic test_random_sender_idle();
    set_parser_cfg(8'h00, 8'hFF, 8'h10, 8'h20);
    src_idle_pct   = 78;
    sink_stall_pct = 0;
    run_frame_mix(PhaseBudget);
  endtask

  task automatic test_random_receiver_stall();
    set_parser_cfg(8'hFF, 8'h00, 8'h00, 8'h02);  // only command 1 is legal
    src_idle_pct   = 0;
    sink_stall_pct = 78;
    run_frame_mix(PhaseBudget);
  endtask

  task automatic test_random_both_idle();
    set_parser_cfg(8'h5A, 8'h5A, 8'h7E, 8'hC0);  // both header bytes alike
    src_idle_pct   = 8;
    sink_stall_pct = 8;
    run_frame_mix(PhaseBudget);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready driver with random stalls and long hold-offs, and checker.
  // ---------------------------------------------------------------------------
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        res_if.ready <= 1'b0;
        hold_off_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (parse_results_q.size() == 0) begin
        if (fault_count < MaxReports)
          $display("%0t: result beat with nothing outstanding, status %0d",
                   $realtime, res_if.status);
        fault_count++;
      end else begin
        want = parse_results_q.pop_front();
        if (res_if.status !== want.status || res_if.payload_valid !== want.payload_valid ||
            res_if.payload_byte !== want.payload_byte ||
            res_if.payload_index !== want.payload_index ||
            res_if.frame_command !== want.frame_command ||
            res_if.frame_length !== want.frame_length) begin
          if (fault_count < MaxReports) begin
            $display("%0t: mismatch, want status %0d pv %0b byte %02h idx %0d cmd %02h len %0d",
                     $realtime, want.status, want.payload_valid, want.payload_byte,
                     want.payload_index, want.frame_command, want.frame_length);
            $display("%0t:            got  status %0d pv %0b byte %02h idx %0d cmd %02h len %0d",
                     $realtime, res_if.status, res_if.payload_valid, res_if.payload_byte,
                     res_if.payload_index, res_if.frame_command, res_if.frame_length);
          end
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.rx_byte = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    beats_sent      = 0;
    fault_count     = 0;
    cycle_count     = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_off_left   = 0;
    parser_cfg      = '{HeaderFirstRst, HeaderSecondRst, CmdLowerRst, CmdUpperRst};
    frame_phase_q   = PH_HEAD1;
    frame_cmd_q     = '0;
    frame_len_q     = '0;
    payload_count_q = '0;
    frame_sum_q     = '0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_header_mismatch();
    test_command_bounds();
    test_checksum_paths();
    test_length_limit();
    test_backpressure();
    test_random_no_idle();
    test_empty_command_range();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    wait_parse_drained();
    fault_count += parse_results_q.size();
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
